### design/tst_pkg.sv
// ----------------------------------------------------------------------------
// Timer slot table package
// Shared types and constants for the timer slot table and its slot cells.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_SET    = 3'd1;
  localparam logic [2:0] MODE_KILL   = 3'd2;
  localparam logic [2:0] MODE_RESET  = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;
  localparam logic [2:0] MODE_REMOVE = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // Operation broadcast from the controller to every cell.
  typedef struct packed {
    logic        walk;
    logic [2:0]  mode;
    logic [31:0] tick;
    logic [31:0] owner;
    logic [31:0] ident;
    logic [31:0] period;
  } op_t;

endpackage

### design/timer_slot_table.sv
// ----------------------------------------------------------------------------
// Timer slot table
// A chain of periodic timer slots keyed by owner and id.
// ----------------------------------------------------------------------------
// Each transaction on the input channel latches now_tick and runs one
// operation: tick check, set, kill, reset, query or remove slot. Operations
// that search the table pass a token down a chain of NUM_SLOTS cells, one cell
// per cycle; remove slot and skipped operations take the same walk for
// simplicity of control. The result is held in an output register until it
// is taken, and a new item is accepted in the cycle after that, so the block
// takes no new item while one is still in flight.
// Set fills the lowest free slot, found from the valid bits once the walk has
// shown no existing match.
// ----------------------------------------------------------------------------
module timer_slot_table import tst_pkg::*; #(
  parameter int NUM_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_now_tick,
  input  logic        in_check_enable,
  input  logic [31:0] in_owner,
  input  logic [31:0] in_timer_id,
  input  logic [31:0] in_interval,
  input  logic [4:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [5:0]  out_hit_count,
  output logic [31:0] out_expired_mask,
  output logic [5:0]  out_active_timers,
  output logic        out_have_free
);

  localparam int CW = $clog2(NUM_SLOTS + 1);

  state_t state_r, state_nxt;
  op_t    op_r;
  logic   en_r;
  logic [4:0] sidx_r;
  logic [CW-1:0] step_r;
  logic [NUM_SLOTS:0] tok, done;
  logic [NUM_SLOTS-1:0] valid, fire, kill, clrf, place, remove, ffree;
  logic [31:0] fired_r, emask_r;
  logic [5:0] occ_r, hits_r;
  logic ok_r;
  logic in_acc, out_acc, start;
  logic active;   // operation actually does something

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign start   = (state_r == ST_IDLE) && in_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_WALK;
      ST_WALK: if (step_r == CW'(NUM_SLOTS)) state_nxt = ST_DONE;
      ST_DONE: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign active = !(op_r.mode == MODE_TICK && !en_r) &&
                  !((op_r.mode == MODE_SET || op_r.mode == MODE_RESET ||
                     op_r.mode == MODE_QUERY) && op_r.ident == 32'd0);

  assign tok[0]  = (state_r == ST_WALK) && (step_r == '0) && active;
  assign done[0] = 1'b0;

  // Lowest free slot, used at the end of a set walk.
  always_comb begin
    logic seen;
    seen  = 1'b0;
    ffree = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!valid[i] && !seen) begin
        ffree[i] = 1'b1;
        seen = 1'b1;
      end
    end
  end

  logic last_step, set_fill;
  assign last_step = (state_r == ST_WALK) && (step_r == CW'(NUM_SLOTS));
  assign set_fill  = last_step && active && op_r.mode == MODE_SET && !ok_r;

  genvar g;
  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      assign place[g]  = set_fill && ffree[g];
      assign remove[g] = last_step && op_r.mode == MODE_REMOVE &&
                         sidx_r == 5'(g) && valid[g];
      tst_cell u_cell (
        .clk(clk), .rst_n(rst_n), .op(op_r),
        .tok_in(tok[g]), .done_in(done[g]),
        .first_free(ffree[g]), .place(place[g]), .remove(remove[g]),
        .tok_out(tok[g+1]), .done_out(done[g+1]),
        .valid(valid[g]), .fire(fire[g]), .kill(kill[g]), .clr_fired(clrf[g])
      );
    end
  endgenerate

  logic any_fire;
  logic [NUM_SLOTS-1:0] fire_m;
  assign fire_m   = fire & tok[NUM_SLOTS-1:0];
  assign any_fire = |fire_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fired_r <= '0;
      occ_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) step_r <= '0;
      else if (state_r == ST_WALK) step_r <= step_r + CW'(1);
      if (state_r == ST_WALK && !last_step) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (fire_m[i] && op_r.mode == MODE_TICK) fired_r[i] <= 1'b1;
          if (clrf[i] && tok[i]) fired_r[i] <= 1'b0;
        end
        if (|(kill & tok[NUM_SLOTS-1:0])) occ_r <= occ_r - 6'd1;
      end
      if (set_fill && !(&valid)) occ_r <= occ_r + 6'd1;
      if (|remove) occ_r <= occ_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r.walk   <= 1'b1;
      op_r.mode   <= in_mode;
      op_r.tick   <= in_now_tick;
      op_r.owner  <= in_owner;
      op_r.ident  <= in_timer_id;
      op_r.period <= (in_mode == MODE_SET && in_interval == 32'd0) ? 32'd1 : in_interval;
      en_r        <= in_check_enable;
      sidx_r      <= in_slot_index;
      ok_r        <= (in_mode == MODE_TICK) && in_check_enable;
      hits_r      <= '0;
      emask_r     <= '0;
    end else if (state_r == ST_WALK && !last_step) begin
      if (any_fire) begin
        if (op_r.mode == MODE_TICK || op_r.mode == MODE_KILL) hits_r <= hits_r + 6'd1;
        if (op_r.mode != MODE_TICK) ok_r <= 1'b1;
      end
      emask_r <= emask_r | ((op_r.mode == MODE_TICK) ? 32'(fire_m) : 32'd0);
    end else if (set_fill && !(&valid)) begin
      ok_r <= 1'b1;
    end else if (|remove) begin
      ok_r <= 1'b1;
    end
  end

  assign out_valid         = (state_r == ST_DONE);
  assign out_ok            = ok_r;
  assign out_hit_count     = hits_r;
  assign out_expired_mask  = emask_r;
  assign out_active_timers = occ_r;
  assign out_have_free     = (occ_r < 6'(NUM_SLOTS));

  logic unused;
  assign unused = tok[NUM_SLOTS] ^ done[NUM_SLOTS] ^ out_acc ^ (|fired_r);

  a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 6'(NUM_SLOTS)) else $error("occupancy above table size");
  a_one_tok: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok[NUM_SLOTS-1:0])) else $error("more than one token");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accepting with result pending");

endmodule

### design/tst_cell.sv
// ----------------------------------------------------------------------------
// Timer slot cell
// One table slot. A token walks down the chain one cell per cycle; the cell
// holding the token performs the current operation on its slot.
// ----------------------------------------------------------------------------
module tst_cell import tst_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  op_t   op,
  input  logic  tok_in,      // this cell is visited this cycle
  input  logic  done_in,     // an earlier cell has finished a single-target op
  input  logic  first_free,  // this cell was chosen as the free slot for set
  input  logic  place,       // write the set operation here
  input  logic  remove,      // remove-slot targets this cell
  output logic  tok_out,
  output logic  done_out,
  output logic  valid,
  output logic  fire,        // this visit fired or matched (counted for tick and kill)
  output logic  kill,        // this visit freed the slot
  output logic  clr_fired
);

  logic        valid_r, valid_nxt;
  logic [31:0] owner_r, ident_r, period_r, due_r;
  logic        tok_r;
  logic        done_r, done_nxt;
  logic        match;
  logic        wr_en;
  logic        id_zero;

  assign id_zero = (op.ident == 32'd0);
  assign match   = valid_r && (owner_r == op.owner) && (ident_r == op.ident);

  always_comb begin
    fire      = 1'b0;
    kill      = 1'b0;
    clr_fired = 1'b0;
    wr_en     = 1'b0;
    done_nxt  = done_in;
    valid_nxt = valid_r;
    if (tok_in && !done_in) begin
      case (op.mode)
        MODE_TICK: begin
          if (valid_r && op.tick >= due_r) fire = 1'b1;
        end
        MODE_SET, MODE_RESET: begin
          if (match) begin
            wr_en     = 1'b1;
            fire      = 1'b1;
            done_nxt  = 1'b1;
            clr_fired = (op.mode == MODE_RESET);
          end
        end
        MODE_KILL: begin
          if (valid_r && owner_r == op.owner && (id_zero || ident_r == op.ident)) begin
            kill      = 1'b1;
            fire      = 1'b1;
            clr_fired = 1'b1;
            valid_nxt = 1'b0;
            done_nxt  = !id_zero;
          end
        end
        MODE_QUERY: begin
          if (match) begin
            fire     = 1'b1;
            done_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (place) valid_nxt = 1'b1;
    if (remove) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (tok_in && op.mode == MODE_TICK && fire) due_r <= op.tick + period_r;
    if (wr_en || place) begin
      period_r <= op.period;
      due_r    <= op.tick + op.period;
    end
    if (place) begin
      owner_r <= op.owner;
      ident_r <= op.ident;
    end
  end

  // Token and done flag are registered before the next cell, so both reach
  // the neighbor in the cycle in which it holds the token.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      tok_r  <= tok_in && op.walk;
      done_r <= done_nxt && op.walk;
    end
  end

  assign tok_out  = tok_r;
  assign done_out = done_r;
  assign valid    = valid_r;

  logic unused;
  assign unused = first_free;

endmodule
